@@ sv/bbc_pkg.sv @@
// Shared types and constants for the bracket balance checker.
// Depends on nothing; all other files but bbc_ram refer to it by scoped names.
package bbc_pkg;

  // Default number of entries on the bracket stack.
  localparam int STACK_DEPTH_DEF = 64;

  // Entries in the queue between the classifier and the stack engine.
  localparam int QUEUE_DEPTH = 2;

  // Item kinds on the input channel.
  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_EOL  = 1'b1;

  // Character codes of interest.
  localparam logic [7:0] CHAR_LPAREN = 8'h28;
  localparam logic [7:0] CHAR_RPAREN = 8'h29;
  localparam logic [7:0] CHAR_LBRACK = 8'h5B;
  localparam logic [7:0] CHAR_RBRACK = 8'h5D;

  // Bracket kinds as held on the stack.
  localparam logic KIND_ROUND  = 1'b0;
  localparam logic KIND_SQUARE = 1'b1;

  // One classified operation for the stack engine.
  typedef struct packed {
    logic eol;   // end of line: report and clear
    logic push;  // opening bracket when set, closing bracket otherwise
    logic kind;  // bracket kind
  } bbc_op_t;

endpackage

@@ sv/bbc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module bbc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/bbc_front.sv @@
// Front end: accepts input items and turns them into stack operations.
// Depends on bbc_pkg; ordinary characters are dropped here and never queued.
module bbc_front (
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_req_type,
  input  logic [7:0]     in_char_code,
  input  logic           q_space,
  output logic           q_push,
  output bbc_pkg::bbc_op_t q_op
);

  logic relevant;

  always_comb begin
    q_op     = '0;
    relevant = 1'b0;
    if (in_req_type == bbc_pkg::REQ_EOL) begin
      q_op.eol = 1'b1;
      relevant = 1'b1;
    end else begin
      case (in_char_code)
        bbc_pkg::CHAR_LPAREN: begin
          q_op.push = 1'b1;
          q_op.kind = bbc_pkg::KIND_ROUND;
          relevant  = 1'b1;
        end
        bbc_pkg::CHAR_LBRACK: begin
          q_op.push = 1'b1;
          q_op.kind = bbc_pkg::KIND_SQUARE;
          relevant  = 1'b1;
        end
        bbc_pkg::CHAR_RPAREN: begin
          q_op.kind = bbc_pkg::KIND_ROUND;
          relevant  = 1'b1;
        end
        bbc_pkg::CHAR_RBRACK: begin
          q_op.kind = bbc_pkg::KIND_SQUARE;
          relevant  = 1'b1;
        end
        default: begin
          relevant = 1'b0;
        end
      endcase
    end
  end

  // An item is taken whenever the queue has room, even if it is then dropped.
  assign in_ready = q_space;
  assign q_push   = in_valid && q_space && relevant;

endmodule

@@ sv/bbc_fifo.sv @@
// Short queue of stack operations between the front end and the stack engine.
// Depends on bbc_pkg for the operation type and the queue depth.
module bbc_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bbc_pkg::bbc_op_t push_op,
  output logic             space,
  input  logic             pop,
  output logic             head_valid,
  output bbc_pkg::bbc_op_t head_op
);

  localparam int PW = (bbc_pkg::QUEUE_DEPTH > 1) ? $clog2(bbc_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(bbc_pkg::QUEUE_DEPTH + 1);

  bbc_pkg::bbc_op_t entries_r [bbc_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(bbc_pkg::QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  assign space      = (count_r != CW'(bbc_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_op    = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

@@ sv/bbc_back.sv @@
// Stack engine: carries out queued operations against the bracket stack.
// Depends on bbc_pkg and bbc_ram, which holds the stack entries.
module bbc_back #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  bbc_pkg::bbc_op_t head_op,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_balanced
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  logic [DW-1:0] depth_r, depth_nxt;
  logic          mismatch_r, mismatch_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_balanced_r, out_balanced_nxt;
  logic          fwd_hit_r;
  logic          fwd_data_r;

  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [DW-1:0] depth_m1;
  logic          ram_rdata;
  logic          top_kind;
  logic          slot_free;

  // The RAM is always reading the entry just below the next depth, so the
  // stack top is ready in the next cycle. A push writes that very entry, so
  // its data is forwarded around the RAM.
  assign top_kind  = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign slot_free = !out_valid_r || out_ready;
  assign pop       = head_valid && (!head_op.eol || slot_free);
  assign waddr     = depth_r[AW-1:0];

  always_comb begin
    depth_nxt        = depth_r;
    mismatch_nxt     = mismatch_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_balanced_nxt = out_balanced_r;
    we               = 1'b0;
    if (pop) begin
      if (head_op.eol) begin
        out_valid_nxt    = 1'b1;
        out_balanced_nxt = !mismatch_r && (depth_r == '0);
        depth_nxt        = '0;
        mismatch_nxt     = 1'b0;
      end else if (!mismatch_r) begin
        if (head_op.push) begin
          if (depth_r == DW'(STACK_DEPTH)) begin
            mismatch_nxt = 1'b1;
          end else begin
            we        = 1'b1;
            depth_nxt = depth_r + DW'(1);
          end
        end else begin
          if (depth_r == '0 || top_kind != head_op.kind) begin
            mismatch_nxt = 1'b1;
          end else begin
            depth_nxt = depth_r - DW'(1);
          end
        end
      end
    end
    depth_m1 = depth_nxt - DW'(1);
    raddr    = depth_m1[AW-1:0];
  end

  bbc_ram #(
    .WIDTH (1),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (head_op.kind),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      mismatch_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_hit_r   <= 1'b0;
    end else begin
      depth_r     <= depth_nxt;
      mismatch_r  <= mismatch_nxt;
      out_valid_r <= out_valid_nxt;
      fwd_hit_r   <= we && (waddr == raddr);
    end
  end

  always_ff @(posedge clk) begin
    out_balanced_r <= out_balanced_nxt;
    fwd_data_r     <= head_op.kind;
  end

  assign out_valid    = out_valid_r;
  assign out_balanced = out_balanced_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head_op.eol |=> depth_r == '0 && !mismatch_r && out_valid_r)
    else $error("end of line did not clear the state");

  a_eol_slot: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head_op.eol |-> slot_free)
    else $error("result issued over a pending result");

  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !head_op.eol && head_op.push && !mismatch_r && depth_r == DW'(STACK_DEPTH)
      |=> mismatch_r && depth_r == DW'(STACK_DEPTH))
    else $error("overflow not flagged");

endmodule

@@ sv/bracket_balance_checker.sv @@
// Bracket balance checker: takes one item per cycle while the queue has room, characters or
// end-of-line markers, and gives one result per line on whether round and square brackets nest
// properly. Ordinary characters are dropped in the front end; brackets pass a two-entry queue
// to the stack engine, which handles one per cycle using the stack top read ahead from the stack
// RAM (with forwarding after a push). A result goes to an output register as its end-of-line
// item leaves the queue and is held there; while it waits, items are still taken until the queue
// fills behind a second end-of-line. Overflow of the STACK_DEPTH-entry stack counts as unbalanced.
module bracket_balance_checker #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_req_type,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_balanced
);

  logic             q_space;
  logic             q_push;
  bbc_pkg::bbc_op_t q_op;
  logic             q_pop;
  logic             head_valid;
  bbc_pkg::bbc_op_t head_op;

  bbc_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_char_code (in_char_code),
    .q_space      (q_space),
    .q_push       (q_push),
    .q_op         (q_op)
  );

  bbc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (q_op),
    .space      (q_space),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head_op      (head_op),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_balanced (out_balanced)
  );

endmodule

@@ sim/bracket_balance_checker_tb.sv @@
// Self-checking testbench for the bracket balance checker: directed lines, stack limits and
// random lines, with random gaps on the input side and random stalls on the result side.
// Depends on bbc_pkg and bracket_balance_checker from the RTL.
module bracket_balance_checker_tb;

  localparam int LIMIT_TIME = 4_000_000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_req_type;
  logic [7:0] in_char_code;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_balanced;

  // Own view of the line being checked.
  logic line_stack [bbc_pkg::STACK_DEPTH_DEF];
  int   line_depth = 0;
  logic line_unbalanced = 1'b0;
  logic verdict_q [$];

  logic [7:0] line_buf [$];
  logic       no_idle = 1'b0;
  int         errors = 0;
  int         items_sent = 0;
  int         lines_sent = 0;
  int         seen_balanced = 0;
  int         seen_unbalanced = 0;

  bracket_balance_checker dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_char_code (in_char_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_balanced (out_balanced)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(LIMIT_TIME);
    $display("timeout: run did not finish, %0d verdicts still pending", verdict_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // Updates the line state for one accepted item and queues a verdict at end of line.
  function automatic void track_bracket_item(logic req, logic [7:0] ch);
    logic kind;
    if (req == bbc_pkg::REQ_EOL) begin
      verdict_q.push_back(!line_unbalanced && line_depth == 0);
      line_depth = 0;
      line_unbalanced = 1'b0;
    end else if (!line_unbalanced) begin
      kind = (ch == bbc_pkg::CHAR_LBRACK || ch == bbc_pkg::CHAR_RBRACK) ?
             bbc_pkg::KIND_SQUARE : bbc_pkg::KIND_ROUND;
      case (ch)
        bbc_pkg::CHAR_LPAREN, bbc_pkg::CHAR_LBRACK: begin
          if (line_depth == bbc_pkg::STACK_DEPTH_DEF) begin
            line_unbalanced = 1'b1;
          end else begin
            line_stack[line_depth] = kind;
            line_depth++;
          end
        end
        bbc_pkg::CHAR_RPAREN, bbc_pkg::CHAR_RBRACK: begin
          if (line_depth == 0 || line_stack[line_depth - 1] != kind) begin
            line_unbalanced = 1'b1;
          end else begin
            line_depth--;
          end
        end
        default: ;
      endcase
    end
  endfunction

  task automatic send_item(logic req, logic [7:0] ch);
    if (!no_idle) begin
      while ($urandom_range(99) < 29) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_char_code <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_bracket_item(req, ch);
    items_sent++;
    if (req == bbc_pkg::REQ_EOL) lines_sent++;
  endtask

  task automatic send_line(string text, logic [7:0] eol_code);
    for (int i = 0; i < text.len(); i++) send_item(bbc_pkg::REQ_CHAR, text[i]);
    send_item(bbc_pkg::REQ_EOL, eol_code);
  endtask

  task automatic send_buffered_line();
    foreach (line_buf[i]) send_item(bbc_pkg::REQ_CHAR, line_buf[i]);
    send_item(bbc_pkg::REQ_EOL, 8'($urandom_range(255)));
  endtask

  function automatic logic [7:0] random_bracket();
    case ($urandom_range(3))
      0: return bbc_pkg::CHAR_LPAREN;
      1: return bbc_pkg::CHAR_RPAREN;
      2: return bbc_pkg::CHAR_LBRACK;
      default: return bbc_pkg::CHAR_RBRACK;
    endcase
  endfunction

  function automatic logic [7:0] random_filler();
    logic [7:0] ch;
    do ch = 8'($urandom_range(255));
    while (ch == bbc_pkg::CHAR_LPAREN || ch == bbc_pkg::CHAR_RPAREN ||
           ch == bbc_pkg::CHAR_LBRACK || ch == bbc_pkg::CHAR_RBRACK);
    return ch;
  endfunction

  // Builds a properly nested line of the given number of pairs; open_bias is the chance in
  // a hundred of opening rather than closing when both are possible.
  task automatic compose_nested(int pairs, int open_bias, logic fillers);
    logic open_kinds [$];
    int   opened;
    logic k;
    line_buf.delete();
    opened = 0;
    while (opened < pairs || open_kinds.size() > 0) begin
      if (fillers && $urandom_range(99) < 25) line_buf.push_back(random_filler());
      if (opened < pairs && (open_kinds.size() == 0 || $urandom_range(99) < open_bias)) begin
        k = 1'($urandom_range(1));
        open_kinds.push_back(k);
        line_buf.push_back(k == bbc_pkg::KIND_SQUARE ? bbc_pkg::CHAR_LBRACK :
                                                       bbc_pkg::CHAR_LPAREN);
        opened++;
      end else begin
        k = open_kinds.pop_back();
        line_buf.push_back(k == bbc_pkg::KIND_SQUARE ? bbc_pkg::CHAR_RBRACK :
                                                       bbc_pkg::CHAR_RPAREN);
      end
    end
  endtask

  task automatic break_line();
    int pos;
    if (line_buf.size() == 0) begin
      line_buf.push_back(bbc_pkg::CHAR_RPAREN);
      return;
    end
    pos = $urandom_range(line_buf.size() - 1);
    case ($urandom_range(2))
      0: line_buf[pos] = random_bracket();
      1: line_buf.delete(pos);
      default: line_buf.insert(pos, random_bracket());
    endcase
  endtask

  task automatic test_directed_lines();
    send_line("", 8'h00);
    send_line("()", 8'hFF);
    send_item(bbc_pkg::REQ_CHAR, bbc_pkg::CHAR_LBRACK);
    send_item(bbc_pkg::REQ_CHAR, bbc_pkg::CHAR_LPAREN);
    send_item(bbc_pkg::REQ_CHAR, 8'h00);
    send_item(bbc_pkg::REQ_CHAR, bbc_pkg::CHAR_RPAREN);
    send_item(bbc_pkg::REQ_CHAR, 8'hFF);
    send_line("].", 8'hA5);
    // Wrong kind of closing bracket; the rest of the line must be ignored.
    send_line("(]])", 8'h5A);
    send_line("][]", bbc_pkg::CHAR_RPAREN);
    send_line("[", bbc_pkg::CHAR_LPAREN);
  endtask

  task automatic test_stack_limits();
    compose_nested(bbc_pkg::STACK_DEPTH_DEF, 100, 1'b0);
    send_buffered_line();
    // One opening bracket more than the stack holds.
    compose_nested(bbc_pkg::STACK_DEPTH_DEF + 1, 100, 1'b0);
    send_buffered_line();
    for (int i = 0; i < bbc_pkg::STACK_DEPTH_DEF; i++) begin
      send_item(bbc_pkg::REQ_CHAR, bbc_pkg::CHAR_LPAREN);
    end
    send_item(bbc_pkg::REQ_EOL, 8'h00);
    send_line("[()]", 8'hFF);
  endtask

  // Sends random lines until the whole run has sent the target number of items.
  task automatic test_random_lines(int target);
    int shape;
    while (items_sent < target) begin
      no_idle = (items_sent >= target * 2 / 5 && items_sent < target * 3 / 5);
      shape = $urandom_range(99);
      if (shape < 3) begin
        compose_nested($urandom_range(bbc_pkg::STACK_DEPTH_DEF - 4,
                                      bbc_pkg::STACK_DEPTH_DEF + 2), 100, 1'b0);
      end else if (shape < 68) begin
        compose_nested($urandom_range(12), 55, 1'b1);
      end else if (shape < 85) begin
        compose_nested($urandom_range(10), 55, 1'b1);
        break_line();
      end else begin
        line_buf.delete();
        repeat ($urandom_range(20))
          line_buf.push_back($urandom_range(1) ? random_bracket() : 8'($urandom_range(255)));
      end
      send_buffered_line();
    end
    no_idle = 1'b0;
  endtask

  always @(negedge clk) out_ready <= no_idle || ($urandom_range(99) >= 29);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("result balanced=%0b with no line outstanding", out_balanced));
      end else begin
        if (out_balanced !== verdict_q[0]) begin
          report_mismatch($sformatf("balanced expected %0b got %0b", verdict_q[0],
                                    out_balanced));
        end
        if (verdict_q[0]) seen_balanced++;
        else seen_unbalanced++;
        void'(verdict_q.pop_front());
      end
    end
  end

  initial begin
    int waited;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req_type  = bbc_pkg::REQ_CHAR;
    in_char_code = 8'h00;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_lines();
    test_stack_limits();
    test_random_lines(1300);

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (verdict_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    while (verdict_q.size() != 0) begin
      report_mismatch($sformatf("verdict %0b never delivered", verdict_q[0]));
      void'(verdict_q.pop_front());
    end

    $display("Sent %0d items over %0d lines, including full and overflowing stacks.",
             items_sent, lines_sent);
    $display("Checked %0d balanced and %0d unbalanced verdicts; %0d mismatches.",
             seen_balanced, seen_unbalanced, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/bbc_pkg.sv
sv/bbc_ram.sv
sv/bbc_front.sv
sv/bbc_fifo.sv
sv/bbc_back.sv
sv/bracket_balance_checker.sv
sim/bracket_balance_checker_tb.sv
